@@ rtl/obrb_pkg.sv @@
`default_nettype none

package obrb_pkg;

    localparam int unsigned DEPTH      = 4096;
    localparam int unsigned ADDR_W     = $clog2(DEPTH);
    localparam int unsigned POS_W      = 31;
    localparam int unsigned HEAD_LIMIT = 1073741824;
    localparam int unsigned HEAD_STEP  = 536870912;

    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_PUBLISH = 2'd1;
    localparam logic [1:0] REQ_READ    = 2'd2;
    localparam logic [1:0] REQ_SEEK    = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_DATA = 2'd1;
    localparam logic [1:0] ST_LAPPED  = 2'd2;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [7:0]       byte_in;
        logic             first_segment;
        logic [POS_W-1:0] position;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [7:0]       byte_out;
        logic [POS_W-1:0] reader_position;
    } rsp_t;

    // increment with the fixed step back once past the limit
    function automatic logic [POS_W-1:0] bump_counter(input logic [POS_W-1:0] v);
        logic [POS_W:0] n;
        n = {1'b0, v} + (POS_W+1)'(1);
        if (n > (POS_W+1)'(HEAD_LIMIT))
        begin
            n = n - (POS_W+1)'(HEAD_STEP);
        end
        return n[POS_W-1:0];
    endfunction

    function automatic logic [POS_W-1:0] drop_step(input logic [POS_W-1:0] v);
        return v - POS_W'(HEAD_STEP);
    endfunction

endpackage

`default_nettype wire

@@ rtl/overwriting_byte_ring_buffer_core.sv @@
`default_nettype none

// Overwriting byte ring buffer with a lap-detecting reader. Every request
// (write byte, publish heads, read byte, seek reader) yields exactly one
// response, registered in the cycle after the request transaction; a new
// request is taken every cycle while the response side keeps up. The ring
// is a DEPTH-byte single-port-style array (one write or one registered
// read per request), so the rate is one request per clock. The byte store
// is not cleared by reset: reading a slot never written returns garbage.
module overwriting_byte_ring_buffer_core
    import obrb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    logic [7:0] mem [DEPTH];

    logic [POS_W-1:0] fill_count_reg, fill_count_next;
    logic [POS_W-1:0] write_position_reg, write_position_next;
    logic [POS_W-1:0] published_start_reg, published_start_next;
    logic [POS_W-1:0] published_end_reg, published_end_next;
    logic [POS_W-1:0] read_position_reg, read_position_next;

    logic             rsp_valid_reg;
    logic [1:0]       status_reg, status_next;
    logic             hit_reg, hit_next;
    logic [7:0]       rdata_reg;

    logic             accept;
    logic             mem_wr;
    logic             mem_rd;
    logic [ADDR_W-1:0] rd_addr;

    logic [POS_W-1:0] rp_adj;
    logic [POS_W-1:0] rp_lap;
    logic signed [POS_W:0] lap_dist;
    logic             lapped;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        fill_count_next      = fill_count_reg;
        write_position_next  = write_position_reg;
        published_start_next = published_start_reg;
        published_end_next   = published_end_reg;
        read_position_next   = read_position_reg;
        status_next          = ST_OK;
        hit_next             = 1'b0;
        mem_wr               = 1'b0;
        mem_rd               = 1'b0;

        rp_adj   = (read_position_reg > fill_count_reg) ? drop_step(read_position_reg)
                                                        : read_position_reg;
        lap_dist = $signed({1'b0, fill_count_reg}) - $signed({1'b0, rp_adj});
        lapped   = lap_dist >= $signed((POS_W+1)'(DEPTH));
        // lap jump goes to the published packet start
        if (lapped)
        begin
            rp_lap = (published_start_reg > fill_count_reg) ? drop_step(published_start_reg)
                                                            : published_start_reg;
        end
        else
        begin
            rp_lap = rp_adj;
        end
        rd_addr = rp_lap[ADDR_W-1:0];

        case (req.req_type)
            REQ_WRITE:
            begin
                fill_count_next     = bump_counter(fill_count_reg);
                write_position_next = bump_counter(write_position_reg);
                mem_wr              = accept;
            end
            REQ_PUBLISH:
            begin
                published_start_next = req.position;
                published_end_next   = write_position_reg;
            end
            REQ_READ:
            begin
                if (lapped && !req.first_segment)
                begin
                    status_next        = ST_LAPPED;
                    read_position_next = rp_lap;
                end
                else if (published_end_reg == rp_lap)
                begin
                    status_next        = ST_NO_DATA;
                    read_position_next = rp_lap;
                end
                else
                begin
                    hit_next           = 1'b1;
                    mem_rd             = accept;
                    read_position_next = rp_lap + POS_W'(1);
                end
            end
            REQ_SEEK:
            begin
                read_position_next = req.position;
            end
            default:
            begin
                read_position_next = read_position_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg      <= '0;
            write_position_reg  <= '0;
            published_start_reg <= '0;
            published_end_reg   <= '0;
            read_position_reg   <= '0;
            rsp_valid_reg       <= 1'b0;
            status_reg          <= ST_OK;
            hit_reg             <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                fill_count_reg      <= fill_count_next;
                write_position_reg  <= write_position_next;
                published_start_reg <= published_start_next;
                published_end_reg   <= published_end_next;
                read_position_reg   <= read_position_next;
                status_reg          <= status_next;
                hit_reg             <= hit_next;
                rsp_valid_reg       <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // ring storage, depth is a power of two so the wrap is the low bits
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            mem[write_position_reg[ADDR_W-1:0]] <= req.byte_in;
        end
        if (mem_rd)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign rsp_valid           = rsp_valid_reg;
    assign rsp.status          = status_reg;
    assign rsp.byte_out        = hit_reg ? rdata_reg : 8'd0;
    assign rsp.reader_position = read_position_reg;

`ifndef SYNTHESIS
    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= POS_W'(HEAD_LIMIT) && write_position_reg <= POS_W'(HEAD_LIMIT))
        else $error("fill or write counter above limit");

    a_non_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.req_type != REQ_READ |=> rsp_valid && rsp.status == ST_OK
        && rsp.byte_out == 8'd0)
        else $error("non-read transaction gave a non-ok response");

    a_seek_pos: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.req_type == REQ_SEEK |=> rsp.reader_position == $past(req.position))
        else $error("seek did not move the reader");

    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && hit_reg |-> rsp.status == ST_OK)
        else $error("data byte returned with an error status");

    a_write_advances: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.req_type == REQ_WRITE |=> write_position_reg != $past(write_position_reg))
        else $error("write did not advance the write head");
`endif

endmodule

`default_nettype wire
